>>> rtl/fptb_pkg.sv
package fptb_pkg;

    // sizes
    localparam int unsigned DEFAULT_SLOTS = 1024;
    localparam int unsigned TOK_W         = 40;
    localparam int unsigned APB_AW        = 3;

    // hash constants
    localparam logic [31:0] HASH_MULT = 32'd2654435761;
    localparam int unsigned HASH_ROT  = 7;
    localparam int unsigned HASH_FOLD = 16;

    // operations
    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // slot status
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_VALID = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    // policy actions
    localparam logic [1:0] ACT_BLOCK = 2'd0;
    localparam logic [1:0] ACT_HARD  = 2'd1;
    localparam logic [1:0] ACT_SOFT  = 2'd2;

    // register indexes
    localparam logic [0:0] REG_BURST   = 1'd0;
    localparam logic [0:0] REG_ENFORCE = 1'd1;

    localparam logic [7:0] BURST_RESET   = 8'd2;
    localparam logic       ENFORCE_RESET = 1'b1;

    // table write kinds
    localparam logic [2:0] WR_NONE    = 3'd0;
    localparam logic [2:0] WR_CLEAR   = 3'd1;
    localparam logic [2:0] WR_FILL    = 3'd2;
    localparam logic [2:0] WR_UPDATE  = 3'd3;
    localparam logic [2:0] WR_CONSUME = 3'd4;
    localparam logic [2:0] WR_TICK    = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [1:0]  policy_action;
        logic [15:0] lifetime_seconds;
        logic [31:0] packet_rate;
    } in_word_t;

    typedef struct packed {
        logic forward;
        logic entry_matched;
        logic insert_ok;
    } out_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      src;
        logic [31:0]      dst;
        logic [1:0]       act;
        logic [15:0]      life;
        logic [31:0]      rate;
        logic [TOK_W-1:0] tokens;
        logic [TOK_W-1:0] cap;
    } slot_t;

    typedef struct packed {
        logic       load_item;
        logic       hash1;
        logic       hash2;
        logic       zero_idx;
        logic       rd_en;
        logic       step;
        logic       note_tomb;
        logic [2:0] wr_kind;
        logic       res_load;
        out_word_t  res;
        logic       post;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] st;
        logic       key_match;
        logic [1:0] act;
        logic       tokens_zero;
        logic       n_last;
        logic       idx_last;
        logic       have_tomb;
        logic       enforce;
        logic       out_free;
    } stat_t;

endpackage

>>> rtl/fptb_dp.sv
module fptb_dp #(
    parameter int unsigned TABLE_SLOTS = fptb_pkg::DEFAULT_SLOTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fptb_pkg::cmd_t      cmd,
    output fptb_pkg::stat_t     stat,
    input  fptb_pkg::in_word_t  s_data,
    input  logic [7:0]          burst_factor,
    input  logic                enforce_enable,
    output logic                m_valid,
    input  logic                m_ready,
    output fptb_pkg::out_word_t m_data
);
    localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
    localparam int unsigned TOK_W = fptb_pkg::TOK_W;

    fptb_pkg::in_word_t  item_reg;
    logic [31:0]         prod_reg;
    logic [TOK_W-1:0]    cap_reg;
    logic [IDX_W-1:0]    idx_reg, n_reg, tomb_reg;
    logic                have_tomb_reg;
    fptb_pkg::slot_t     rd_reg;
    fptb_pkg::out_word_t res_reg, out_reg;
    logic                out_valid_reg;

    fptb_pkg::slot_t     mem [TABLE_SLOTS];

    logic [31:0]      key, prod_next, mix;
    logic [TOK_W-1:0] cap_next;
    logic [TOK_W:0]   refill;
    logic [15:0]      life_dec;
    fptb_pkg::slot_t  wdata;
    logic [IDX_W-1:0] waddr;
    logic             wr_en;

    // hash: xor with rotated destination, multiply, fold
    assign key = item_reg.source_address ^
                 {item_reg.destination_address[31-fptb_pkg::HASH_ROT:0],
                  item_reg.destination_address[31:32-fptb_pkg::HASH_ROT]};
    assign prod_next = key * fptb_pkg::HASH_MULT;
    assign mix       = prod_reg ^ (prod_reg >> fptb_pkg::HASH_FOLD);
    assign cap_next  = TOK_W'(item_reg.packet_rate) * TOK_W'(burst_factor);

    // item, hash and probe registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) item_reg <= s_data;
        if (cmd.hash1) begin
            prod_reg <= prod_next;
            cap_reg  <= cap_next;
        end
        if (cmd.note_tomb) tomb_reg <= idx_reg;
        if (cmd.res_load) res_reg <= cmd.res;
        if (cmd.post) out_reg <= res_reg;
        if (cmd.rd_en) rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            n_reg         <= '0;
            have_tomb_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.zero_idx) begin
                idx_reg <= '0;
                n_reg   <= '0;
            end else if (cmd.hash2) begin
                idx_reg       <= mix[IDX_W-1:0];
                n_reg         <= '0;
                have_tomb_reg <= 1'b0;
            end else if (cmd.step) begin
                idx_reg <= idx_reg + 1'b1;
                n_reg   <= n_reg + 1'b1;
            end
            if (cmd.note_tomb) have_tomb_reg <= 1'b1;
            if (cmd.post) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    // write data
    assign life_dec = (rd_reg.life != 16'd0) ? rd_reg.life - 16'd1 : 16'd0;
    assign refill   = {1'b0, rd_reg.tokens} + (TOK_W + 1)'(rd_reg.rate);

    always_comb begin
        wdata = rd_reg;
        waddr = idx_reg;
        wr_en = 1'b1;
        case (cmd.wr_kind)
            fptb_pkg::WR_CLEAR: begin
                wdata        = '0;
                wdata.status = fptb_pkg::ST_EMPTY;
            end
            fptb_pkg::WR_FILL: begin
                waddr        = have_tomb_reg ? tomb_reg : idx_reg;
                wdata.status = fptb_pkg::ST_VALID;
                wdata.src    = item_reg.source_address;
                wdata.dst    = item_reg.destination_address;
                wdata.act    = item_reg.policy_action;
                wdata.life   = item_reg.lifetime_seconds;
                wdata.rate   = item_reg.packet_rate;
                wdata.cap    = cap_reg;
                wdata.tokens = cap_reg;
            end
            fptb_pkg::WR_UPDATE: begin
                wdata.act  = item_reg.policy_action;
                wdata.life = item_reg.lifetime_seconds;
                wdata.rate = item_reg.packet_rate;
                wdata.cap  = cap_reg;
                if (rd_reg.rate != item_reg.packet_rate) wdata.tokens = cap_reg;
            end
            fptb_pkg::WR_CONSUME: begin
                wdata.tokens = rd_reg.tokens - 1'b1;
            end
            fptb_pkg::WR_TICK: begin
                wdata.life = life_dec;
                if (life_dec == 16'd0) begin
                    wdata.status = fptb_pkg::ST_TOMB;
                end else if (rd_reg.act == fptb_pkg::ACT_HARD ||
                             rd_reg.act == fptb_pkg::ACT_SOFT) begin
                    wdata.tokens = (refill > {1'b0, rd_reg.cap}) ? rd_reg.cap
                                                                 : refill[TOK_W-1:0];
                end
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[waddr] <= wdata;
    end

    // status to the controller
    always_comb begin
        stat.op          = item_reg.operation;
        stat.st          = rd_reg.status;
        stat.key_match   = rd_reg.status == fptb_pkg::ST_VALID &&
                           rd_reg.src == item_reg.source_address &&
                           rd_reg.dst == item_reg.destination_address;
        stat.act         = rd_reg.act;
        stat.tokens_zero = rd_reg.tokens == '0;
        stat.n_last      = n_reg == {IDX_W{1'b1}};
        stat.idx_last    = idx_reg == {IDX_W{1'b1}};
        stat.have_tomb   = have_tomb_reg;
        stat.enforce     = enforce_enable;
        stat.out_free    = !out_valid_reg || m_ready;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> rtl/fptb_ctrl.sv
module fptb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fptb_pkg::stat_t stat,
    output fptb_pkg::cmd_t  cmd
);
    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH1  = 4'd2;
    localparam logic [3:0] S_HASH2  = 4'd3;
    localparam logic [3:0] S_PROBE  = 4'd4;
    localparam logic [3:0] S_EVAL   = 4'd5;
    localparam logic [3:0] S_TICKRD = 4'd6;
    localparam logic [3:0] S_TICKEV = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       clr_resp_reg, clr_resp_next;
    logic       rl_act;

    assign s_ready = state_reg == S_IDLE;
    assign rl_act  = stat.act == fptb_pkg::ACT_HARD || stat.act == fptb_pkg::ACT_SOFT;

    always_comb begin
        state_next    = state_reg;
        clr_resp_next = clr_resp_reg;
        cmd           = '0;
        cmd.wr_kind   = fptb_pkg::WR_NONE;
        cmd.res       = '{forward: 1'b1, entry_matched: 1'b0, insert_ok: 1'b0};
        case (state_reg)
            S_CLR: begin
                cmd.wr_kind = fptb_pkg::WR_CLEAR;
                cmd.step    = 1'b1;
                if (stat.idx_last) begin
                    if (clr_resp_reg) begin
                        cmd.res_load  = 1'b1;
                        clr_resp_next = 1'b0;
                        state_next    = S_FIN;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_HASH1;
                end
            end
            S_HASH1: begin
                cmd.hash1 = 1'b1;
                case (stat.op)
                    fptb_pkg::OP_CHECK, fptb_pkg::OP_INSERT: state_next = S_HASH2;
                    fptb_pkg::OP_TICK: begin
                        cmd.zero_idx = 1'b1;
                        state_next   = S_TICKRD;
                    end
                    default: begin
                        cmd.zero_idx  = 1'b1;
                        clr_resp_next = 1'b1;
                        state_next    = S_CLR;
                    end
                endcase
            end
            S_HASH2: begin
                cmd.hash2  = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE: begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                state_next = S_FIN;
                cmd.res_load = 1'b1;
                if (stat.op == fptb_pkg::OP_CHECK) begin
                    if (stat.key_match) begin
                        cmd.res.entry_matched = 1'b1;
                        if (stat.enforce) begin
                            if (stat.act == fptb_pkg::ACT_BLOCK) begin
                                cmd.res.forward = 1'b0;
                            end else if (rl_act) begin
                                if (stat.tokens_zero) cmd.res.forward = 1'b0;
                                else cmd.wr_kind = fptb_pkg::WR_CONSUME;
                            end
                        end
                    end else if (stat.st != fptb_pkg::ST_EMPTY && !stat.n_last) begin
                        cmd.res_load = 1'b0;
                        cmd.step     = 1'b1;
                        state_next   = S_PROBE;
                    end
                end else begin
                    // insert or update
                    if (stat.key_match) begin
                        cmd.wr_kind       = fptb_pkg::WR_UPDATE;
                        cmd.res.insert_ok = 1'b1;
                    end else if (stat.st == fptb_pkg::ST_EMPTY) begin
                        cmd.wr_kind       = fptb_pkg::WR_FILL;
                        cmd.res.insert_ok = 1'b1;
                    end else if (stat.st == fptb_pkg::ST_TOMB) begin
                        if (stat.n_last) begin
                            cmd.wr_kind       = fptb_pkg::WR_FILL;
                            cmd.res.insert_ok = 1'b1;
                        end else begin
                            cmd.note_tomb = !stat.have_tomb;
                            cmd.res_load  = 1'b0;
                            cmd.step      = 1'b1;
                            state_next    = S_PROBE;
                        end
                    end else if (stat.n_last) begin
                        if (stat.have_tomb) begin
                            cmd.wr_kind       = fptb_pkg::WR_FILL;
                            cmd.res.insert_ok = 1'b1;
                        end
                    end else begin
                        cmd.res_load = 1'b0;
                        cmd.step     = 1'b1;
                        state_next   = S_PROBE;
                    end
                end
            end
            S_TICKRD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_TICKEV;
            end
            S_TICKEV: begin
                if (stat.st == fptb_pkg::ST_VALID) cmd.wr_kind = fptb_pkg::WR_TICK;
                if (stat.n_last) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_FIN;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_TICKRD;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_resp_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_resp_reg <= clr_resp_next;
        end
    end

    // a result word is only posted into a free output register
    a_post_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.post |-> stat.out_free) else $error("result posted over pending word");

    // table writes only from sweep or evaluate states
    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_kind != fptb_pkg::WR_NONE |->
            (state_reg == S_CLR || state_reg == S_EVAL || state_reg == S_TICKEV))
        else $error("table write outside sweep or evaluate");

    // evaluate always follows a read
    a_eval_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL || state_reg == S_TICKEV) |-> $past(cmd.rd_en))
        else $error("evaluate without read");

    // no input word taken during a clear sweep
    a_no_accept_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLR |-> !s_ready) else $error("accept during clear");

endmodule

>>> rtl/flow_policy_table_token_bucket.sv
// Channel   Direction  Payload               Handshake
// s_*       in         fptb_pkg::in_word_t   s_valid / s_ready
// m_*       out        fptb_pkg::out_word_t  m_valid / m_ready
// apb       in/out     burst, enforce regs   psel / penable, pready=1
//
// Check/insert: setup (accept, then two hash stages), then a read and an
// evaluate step per probed slot (one table read port), then the result post.
// Tick: a read and an evaluate step for each of the TABLE_SLOTS; clear: one
// write per slot. After reset a clearing pass over all slots holds s_ready low.
// A finished word waits in the output register; the next word is accepted
// meanwhile, and its result holds until m_ready frees that register.
module flow_policy_table_token_bucket #(
    parameter int unsigned TABLE_SLOTS = fptb_pkg::DEFAULT_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fptb_pkg::in_word_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fptb_pkg::out_word_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fptb_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    fptb_pkg::cmd_t  cmd;
    fptb_pkg::stat_t stat;
    logic [7:0]      burst_reg;
    logic            enforce_reg;
    logic            cfg_wr;

    // config registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg   <= fptb_pkg::BURST_RESET;
            enforce_reg <= fptb_pkg::ENFORCE_RESET;
        end else if (cfg_wr && paddr[1:0] == 2'd0) begin
            case (paddr[2])
                fptb_pkg::REG_BURST:   burst_reg   <= pwdata[7:0];
                fptb_pkg::REG_ENFORCE: enforce_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            fptb_pkg::REG_BURST:   prdata = {24'd0, burst_reg};
            fptb_pkg::REG_ENFORCE: prdata = {31'd0, enforce_reg};
            default:               prdata = '0;
        endcase
    end

    fptb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fptb_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_data         (s_data),
        .burst_factor   (burst_reg),
        .enforce_enable (enforce_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

>>> tb/sv/tb_flow_policy_table_token_bucket.sv
module tb_flow_policy_table_token_bucket;

    localparam int unsigned SLOTS      = fptb_pkg::DEFAULT_SLOTS;
    localparam int unsigned TOK_W      = fptb_pkg::TOK_W;
    localparam int unsigned STALL_MAX  = 20000;
    localparam int unsigned POOL_SIZE  = 32;
    localparam int unsigned FILL_COUNT = 1024;

    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    fptb_pkg::in_word_t            s_data  = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    fptb_pkg::out_word_t           m_data;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [fptb_pkg::APB_AW-1:0]   paddr   = '0;
    logic [31:0]                   pwdata  = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    flow_policy_table_token_bucket uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the flow table and registers
    logic [1:0]       tbl_status [SLOTS];
    logic [31:0]      tbl_src    [SLOTS];
    logic [31:0]      tbl_dst    [SLOTS];
    logic [1:0]       tbl_act    [SLOTS];
    logic [15:0]      tbl_life   [SLOTS];
    logic [31:0]      tbl_rate   [SLOTS];
    logic [TOK_W-1:0] tbl_tokens [SLOTS];
    logic [TOK_W-1:0] tbl_cap    [SLOTS];
    logic [7:0]       cur_burst   = fptb_pkg::BURST_RESET;
    logic             cur_enforce = fptb_pkg::ENFORCE_RESET;

    fptb_pkg::in_word_t  word_q[$];
    fptb_pkg::out_word_t verdict_q[$];
    int        err_count     = 0;
    int        tx_idle_pct   = 0;
    int        rx_idle_pct   = 0;
    int        rx_hold_ask   = 0;
    int        rx_hold_taken = 0;
    int        rx_hold_cnt   = 0;
    int        stall_cycles  = 0;
    logic [31:0] pool_src [POOL_SIZE];
    logic [31:0] pool_dst [POOL_SIZE];

    function automatic int unsigned flow_hash(logic [31:0] src, logic [31:0] dst);
        logic [31:0] k;
        k = src ^ {dst[31-fptb_pkg::HASH_ROT:0], dst[31:32-fptb_pkg::HASH_ROT]};
        k = k * fptb_pkg::HASH_MULT;
        k = k ^ (k >> fptb_pkg::HASH_FOLD);
        return k & (SLOTS - 1);
    endfunction

    function automatic logic [TOK_W-1:0] bucket_cap(logic [31:0] rate);
        return TOK_W'(rate) * TOK_W'(cur_burst);
    endfunction

    function automatic void wipe_flows();
        for (int i = 0; i < SLOTS; i++) begin
            tbl_status[i] = fptb_pkg::ST_EMPTY;
            tbl_src[i] = '0; tbl_dst[i] = '0; tbl_act[i] = '0; tbl_life[i] = '0;
            tbl_rate[i] = '0; tbl_tokens[i] = '0; tbl_cap[i] = '0;
        end
    endfunction

    function automatic void fill_flow(int unsigned i, fptb_pkg::in_word_t w);
        tbl_status[i] = fptb_pkg::ST_VALID;
        tbl_src[i]    = w.source_address;
        tbl_dst[i]    = w.destination_address;
        tbl_act[i]    = w.policy_action;
        tbl_life[i]   = w.lifetime_seconds;
        tbl_rate[i]   = w.packet_rate;
        tbl_cap[i]    = bucket_cap(w.packet_rate);
        tbl_tokens[i] = tbl_cap[i];
    endfunction

    function automatic logic flow_hit(int unsigned i, logic [31:0] src, logic [31:0] dst);
        return tbl_status[i] == fptb_pkg::ST_VALID && tbl_src[i] == src && tbl_dst[i] == dst;
    endfunction

    function automatic logic rate_act(logic [1:0] a);
        return a == fptb_pkg::ACT_HARD || a == fptb_pkg::ACT_SOFT;
    endfunction

    // apply one word to the shadow table, return the verdict it should produce
    function automatic fptb_pkg::out_word_t police_word(fptb_pkg::in_word_t w);
        fptb_pkg::out_word_t v;
        int unsigned base, i, tomb;
        logic        have_tomb, done;
        logic [TOK_W:0] sum;
        v = '{forward: 1'b1, entry_matched: 1'b0, insert_ok: 1'b0};
        base = flow_hash(w.source_address, w.destination_address);
        case (w.operation)
            fptb_pkg::OP_CHECK: begin
                done = 1'b0;
                for (int n = 0; n < SLOTS && !done; n++) begin
                    i = (base + n) & (SLOTS - 1);
                    if (tbl_status[i] == fptb_pkg::ST_EMPTY) begin
                        done = 1'b1;
                    end else if (flow_hit(i, w.source_address, w.destination_address)) begin
                        done = 1'b1;
                        v.entry_matched = 1'b1;
                        if (cur_enforce) begin
                            if (tbl_act[i] == fptb_pkg::ACT_BLOCK) begin
                                v.forward = 1'b0;
                            end else if (rate_act(tbl_act[i])) begin
                                if (tbl_tokens[i] == 0) v.forward = 1'b0;
                                else tbl_tokens[i] = tbl_tokens[i] - 1;
                            end
                        end
                    end
                end
            end
            fptb_pkg::OP_INSERT: begin
                done = 1'b0;
                have_tomb = 1'b0;
                tomb = 0;
                for (int n = 0; n < SLOTS && !done; n++) begin
                    i = (base + n) & (SLOTS - 1);
                    if (flow_hit(i, w.source_address, w.destination_address)) begin
                        done = 1'b1;
                        tbl_act[i]  = w.policy_action;
                        tbl_life[i] = w.lifetime_seconds;
                        tbl_cap[i]  = bucket_cap(w.packet_rate);
                        if (tbl_rate[i] != w.packet_rate) tbl_tokens[i] = tbl_cap[i];
                        tbl_rate[i] = w.packet_rate;
                    end else if (tbl_status[i] == fptb_pkg::ST_TOMB) begin
                        if (!have_tomb) begin
                            have_tomb = 1'b1;
                            tomb = i;
                        end
                    end else if (tbl_status[i] == fptb_pkg::ST_EMPTY) begin
                        done = 1'b1;
                        fill_flow(have_tomb ? tomb : i, w);
                    end
                end
                // probed the whole table without an empty slot
                if (!done && have_tomb) begin
                    done = 1'b1;
                    fill_flow(tomb, w);
                end
                v.insert_ok = done;
            end
            fptb_pkg::OP_TICK: begin
                for (int j = 0; j < SLOTS; j++) begin
                    if (tbl_status[j] == fptb_pkg::ST_VALID) begin
                        if (tbl_life[j] != 0) tbl_life[j] = tbl_life[j] - 1;
                        if (tbl_life[j] == 0) begin
                            tbl_status[j] = fptb_pkg::ST_TOMB;
                        end else if (rate_act(tbl_act[j])) begin
                            sum = {1'b0, tbl_tokens[j]} + (TOK_W+1)'(tbl_rate[j]);
                            if (sum > {1'b0, tbl_cap[j]}) sum = {1'b0, tbl_cap[j]};
                            tbl_tokens[j] = sum[TOK_W-1:0];
                        end
                    end
                end
            end
            default: wipe_flows();
        endcase
        return v;
    endfunction

    // word builders; unused fields carry random noise
    function automatic fptb_pkg::in_word_t noise_word(logic [1:0] op);
        fptb_pkg::in_word_t w;
        w.operation           = op;
        w.source_address      = $urandom;
        w.destination_address = $urandom;
        w.policy_action       = 2'($urandom_range(3));
        w.lifetime_seconds    = 16'($urandom);
        w.packet_rate         = $urandom;
        return w;
    endfunction

    function automatic fptb_pkg::in_word_t check_word(logic [31:0] src, logic [31:0] dst);
        fptb_pkg::in_word_t w;
        w = noise_word(fptb_pkg::OP_CHECK);
        w.source_address = src;
        w.destination_address = dst;
        return w;
    endfunction

    function automatic fptb_pkg::in_word_t insert_word(logic [31:0] src, logic [31:0] dst,
                                                       logic [1:0] act, logic [15:0] life,
                                                       logic [31:0] rate);
        fptb_pkg::in_word_t w;
        w = noise_word(fptb_pkg::OP_INSERT);
        w.source_address = src;
        w.destination_address = dst;
        w.policy_action = act;
        w.lifetime_seconds = life;
        w.packet_rate = rate;
        return w;
    endfunction

    function automatic fptb_pkg::in_word_t random_word();
        int          r, k, pick;
        logic [1:0]  act;
        logic [15:0] life;
        logic [31:0] rate;
        r = $urandom_range(99);
        k = $urandom_range(POOL_SIZE - 1);
        pick = $urandom_range(99);
        act  = (pick < 8) ? 2'd3 : 2'($urandom_range(2));
        pick = $urandom_range(99);
        life = (pick < 10) ? 16'd0 : (pick < 75) ? 16'($urandom_range(1, 6)) : 16'($urandom);
        pick = $urandom_range(99);
        rate = (pick < 10) ? 32'd0 : (pick < 60) ? 32'($urandom_range(1, 4)) : 32'($urandom);
        if (r < 58) return check_word(pool_src[k], pool_dst[k]);
        if (r < 63) return noise_word(fptb_pkg::OP_CHECK);
        if (r < 90) return insert_word(pool_src[k], pool_dst[k], act, life, rate);
        if (r < 93) return insert_word($urandom, $urandom, act, life, rate);
        if (r < 98) return noise_word(fptb_pkg::OP_TICK);
        return noise_word(fptb_pkg::OP_CLEAR);
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) verdict_q.push_back(police_word(s_data));
            if (!s_valid || s_ready) begin
                if (word_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_data  <= word_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %b", $time, m_data);
                    err_count++;
                end else begin
                    fptb_pkg::out_word_t e;
                    e = verdict_q.pop_front();
                    if (e.forward !== m_data.forward) begin
                        $display("%0t: forward expected %b actual %b",
                                 $time, e.forward, m_data.forward);
                        err_count++;
                    end
                    if (e.entry_matched !== m_data.entry_matched) begin
                        $display("%0t: entry_matched expected %b actual %b",
                                 $time, e.entry_matched, m_data.entry_matched);
                        err_count++;
                    end
                    if (e.insert_ok !== m_data.insert_ok) begin
                        $display("%0t: insert_ok expected %b actual %b",
                                 $time, e.insert_ok, m_data.insert_ok);
                        err_count++;
                    end
                end
            end
            if (rx_hold_cnt > 0) begin
                rx_hold_cnt--;
                m_ready <= 1'b0;
            end else if (rx_hold_ask != rx_hold_taken) begin
                rx_hold_taken = rx_hold_ask;
                rx_hold_cnt = 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("tb_flow_policy_table_token_bucket: done, errors");
            $finish;
        end
    end

    task automatic wait_idle();
        while (word_q.size() > 0 || s_valid || verdict_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic reg_write(logic [0:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == fptb_pkg::REG_BURST) cur_burst = val[7:0];
        else cur_enforce = val[0];
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) word_q.push_back(random_word());
        wait_idle();
    endtask

    initial begin
        logic [31:0] a, b, fsrc, fdst;
        wipe_flows();
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_src[k] = $urandom;
            pool_dst[k] = $urandom;
        end
        a = 32'hFFFF_FFFF;
        b = 32'h0000_0000;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: each action, bucket drain, refill, expiry, update, clear
        word_q.push_back(insert_word(a, b, fptb_pkg::ACT_BLOCK, 16'hFFFF, 32'hFFFF_FFFF));
        word_q.push_back(check_word(a, b));
        word_q.push_back(insert_word(b, a, fptb_pkg::ACT_HARD, 16'd5, 32'd1));
        word_q.push_back(check_word(b, a));
        word_q.push_back(check_word(b, a));
        word_q.push_back(check_word(b, a));
        word_q.push_back(noise_word(fptb_pkg::OP_TICK));
        word_q.push_back(check_word(b, a));
        word_q.push_back(insert_word(b, a, fptb_pkg::ACT_SOFT, 16'd5, 32'd1));
        word_q.push_back(check_word(b, a));
        word_q.push_back(insert_word(b, a, fptb_pkg::ACT_SOFT, 16'd5, 32'd3));
        word_q.push_back(check_word(b, a));
        word_q.push_back(insert_word(b, b, fptb_pkg::ACT_SOFT, 16'd9, 32'd0));
        word_q.push_back(check_word(b, b));
        word_q.push_back(insert_word(a, a, 2'd3, 16'd9, 32'd7));
        word_q.push_back(check_word(a, a));
        word_q.push_back(insert_word(32'h1234_5678, a, fptb_pkg::ACT_HARD, 16'd0, 32'd2));
        word_q.push_back(check_word(32'h1234_5678, a));
        word_q.push_back(noise_word(fptb_pkg::OP_TICK));
        word_q.push_back(check_word(32'h1234_5678, a));
        word_q.push_back(check_word(32'hDEAD_BEEF, 32'hCAFE_F00D));
        word_q.push_back(noise_word(fptb_pkg::OP_CLEAR));
        word_q.push_back(check_word(a, b));
        wait_idle();

        // phase: sender light idle, receiver heavy idle, max burst
        reg_write(fptb_pkg::REG_BURST, 32'd255);
        reg_write(fptb_pkg::REG_ENFORCE, 32'd1);
        tx_idle_pct = 22; rx_idle_pct = 87;
        random_phase(250);

        // phase: shadow mode, burst of one
        reg_write(fptb_pkg::REG_BURST, 32'd1);
        reg_write(fptb_pkg::REG_ENFORCE, 32'd0);
        tx_idle_pct = 87; rx_idle_pct = 22;
        random_phase(250);

        // phase: zero burst, enforcing, no idling, one long receiver stall
        reg_write(fptb_pkg::REG_BURST, 32'd0);
        reg_write(fptb_pkg::REG_ENFORCE, 32'd1);
        tx_idle_pct = 0; rx_idle_pct = 0;
        rx_hold_ask++;
        random_phase(250);

        // fill the table completely; a fifth of the entries expire on one tick
        reg_write(fptb_pkg::REG_BURST, 32'($urandom_range(1, 254)));
        word_q.push_back(noise_word(fptb_pkg::OP_CLEAR));
        fsrc = $urandom;
        fdst = $urandom;
        for (int n = 0; n < FILL_COUNT; n++)
            word_q.push_back(insert_word(fsrc + 32'(n), fdst, 2'($urandom_range(2)),
                                         (n % 5 == 0) ? 16'd1 : 16'd60000,
                                         32'($urandom_range(0, 3))));
        word_q.push_back(insert_word(fsrc - 1, fdst, fptb_pkg::ACT_HARD, 16'd4, 32'd1));
        word_q.push_back(check_word(fsrc - 1, fdst));
        word_q.push_back(check_word(fsrc + 3, fdst));
        word_q.push_back(noise_word(fptb_pkg::OP_TICK));
        // no empty slot left, so new keys land on tombstones
        for (int n = 0; n < 40; n++) begin
            word_q.push_back(insert_word(fsrc - 2 - 32'(n), fdst, fptb_pkg::ACT_HARD,
                                         16'd3, 32'd2));
            word_q.push_back(check_word(fsrc - 2 - 32'(n), fdst));
        end
        word_q.push_back(check_word(fsrc, fdst));
        word_q.push_back(noise_word(fptb_pkg::OP_CLEAR));
        wait_idle();

        if (err_count == 0) begin
            $display("tb_flow_policy_table_token_bucket: done, clean");
        end else begin
            $display("tb_flow_policy_table_token_bucket: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/fptb_pkg.sv
rtl/fptb_dp.sv
rtl/fptb_ctrl.sv
rtl/flow_policy_table_token_bucket.sv
tb/sv/tb_flow_policy_table_token_bucket.sv
